@@ rtl/core/sps_pkg.sv @@
// Shared constants and types for the shuffle playlist sequencer.
`timescale 1ns / 1ps

package sps_pkg;

  // Payload widths
  localparam int unsigned TRACK_W    = 16;
  localparam int unsigned SEED_W     = 16;
  localparam int unsigned LEN_W      = 16;

  // Register port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index, taken from the word address
  typedef enum logic {
    REG_PLAYLIST_LENGTH = 1'b0
  } reg_index_e;

  // Generator multiplier: low two bits forced to 01
  localparam logic [63:0] GEN_MULT = (64'd6364136223846793005 & ~64'd3) | 64'd1;

  // Inverse modulo 2^64 by Newton steps (elaboration only)
  function automatic logic [63:0] gen_inverse(input logic [63:0] m);
    logic [63:0] x;
    x = m;
    for (int k = 0; k < 6; k++) begin
      x = x * (64'd2 - m * x);
    end
    return x;
  endfunction

  localparam logic [63:0] GEN_INV   = gen_inverse(GEN_MULT);

  // Reset values of the generator
  localparam logic [63:0] RESET_GEN = 64'd42;
  localparam logic [63:0] RESET_INC = 64'd1013904223;

endpackage

@@ rtl/core/sps_if.sv @@
// Request and response channel interfaces of the shuffle playlist sequencer.
`timescale 1ns / 1ps

interface sps_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic                        repeat_mode;
  logic                        random_mode;
  logic [sps_pkg::SEED_W-1:0]  reseed_value;

  modport source (output valid, func, repeat_mode, random_mode, reseed_value,
                  input ready);
  modport sink   (input valid, func, repeat_mode, random_mode, reseed_value,
                  output ready);
endinterface

interface sps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sps_pkg::TRACK_W-1:0] track_index;
  logic                        found;

  modport source (output valid, track_index, found, input ready);
  modport sink   (input valid, track_index, found, output ready);
endinterface

@@ rtl/core/shuffle_playlist_sequencer.sv @@
// Shuffle playlist sequencer: picks the next or previous track, in order or shuffled.
`timescale 1ns / 1ps

// One request at a time, one response per request. A request is taken only
// when the sequencer is idle; the response sits in an output register, so a
// new request may be taken while the last response still waits. Sequential
// requests are settled in the decide state and go straight to emit, except
// next-track with repeat, which first runs a bit-serial remainder unit.
// Shuffle requests take k generator steps, k being the number of steps until
// a value lands inside the list (k averages under two); each step is a
// shift-and-add multiply, one multiplier bit per cycle. Empty-list and
// spent-pass requests also end in the decide state. The user must write the list
// length through the register port at address 0 while idle; the block does not enforce it.

module shuffle_playlist_sequencer #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sps_req_if.sink                         req_i,
  sps_rsp_if.source                       rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sps_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned WB = (IB > sps_pkg::LEN_W) ? IB : sps_pkg::LEN_W;
  localparam int unsigned CW = $clog2(IB + 1);

  localparam logic [IB-1:0] MULT_IB = sps_pkg::GEN_MULT[IB-1:0];
  localparam logic [IB-1:0] INV_IB  = sps_pkg::GEN_INV[IB-1:0];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SETUP,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Control and architectural state
  state_e                      state_q, state_d;
  logic [sps_pkg::LEN_W-1:0]   plen_q, plen_d;
  logic [IB-1:0]               cur_q, cur_d;
  logic [IB-1:0]               sc_q, sc_d;
  logic [IB-1:0]               gen_q, gen_d;
  logic [IB-1:0]               inc_q, inc_d;
  logic                        rsp_valid_q, rsp_valid_d;

  // Payload and datapath registers
  logic                        func_q, func_d;
  logic                        rep_q, rep_d;
  logic                        rnd_q, rnd_d;
  logic [sps_pkg::SEED_W-1:0]  reseed_q, reseed_d;
  logic                        found_q, found_d;
  logic [sps_pkg::TRACK_W-1:0] rsp_track_q, rsp_track_d;
  logic                        rsp_found_q, rsp_found_d;
  logic [IB-1:0]               x_q, x_d;
  logic [IB-1:0]               acc_q, acc_d;
  logic [IB-1:0]               opnd_q, opnd_d;
  logic [IB-1:0]               mcand_q, mcand_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [IB:0]                 num_q, num_d;
  logic [IB-1:0]               rem_q, rem_d;

  // Derived values
  logic [WB-1:0]               len_w, cap_w, len_clip, seed_w, trk_w;
  logic [IB-1:0]               len, len_m1, range_mask, walk_x, seed_ib, cur_m1;
  logic [IB:0]                 cur_inc, div_shift, div_new;
  logic                        spent, slot_free, cfg_wr;

  // Length clamped to what the index width can hold
  assign len_w    = WB'(plen_q);
  assign cap_w    = {WB{1'b1}} >> (WB - IB);
  assign len_clip = (len_w > cap_w) ? cap_w : len_w;
  assign len      = len_clip[IB-1:0];
  assign len_m1   = len - IB'(1);

  // Generator range: smallest power of two covering the list, minus one
  always_comb begin
    range_mask = len_m1;
    for (int s = 1; s < IB; s = s * 2) begin
      range_mask = range_mask | (range_mask >> s);
    end
  end

  assign walk_x    = acc_q & range_mask;
  assign seed_w    = WB'(reseed_q);
  assign seed_ib   = seed_w[IB-1:0] | IB'(1);
  assign cur_inc   = {1'b0, cur_q} + (IB + 1)'(1);
  assign cur_m1    = cur_q - IB'(1);
  assign trk_w     = WB'(cur_q);

  // Restoring remainder step
  assign div_shift = {rem_q, num_q[IB]};
  assign div_new   = (div_shift >= {1'b0, len}) ? (div_shift - {1'b0, len}) : div_shift;

  assign spent     = func_q ? (sc_q == '0) : (sc_q >= len);
  assign slot_free = !rsp_valid_q || rsp_o.ready;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (sps_pkg::reg_index_e'(paddr[sps_pkg::APB_ADDR_W-1]))
      sps_pkg::REG_PLAYLIST_LENGTH: prdata = sps_pkg::APB_DATA_W'(plen_q);
      default:                      prdata = '0;
    endcase
  end

  // Handshake outputs
  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.track_index = rsp_track_q;
  assign rsp_o.found       = rsp_found_q;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    plen_d      = plen_q;
    cur_d       = cur_q;
    sc_d        = sc_q;
    gen_d       = gen_q;
    inc_d       = inc_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    func_d      = func_q;
    rep_d       = rep_q;
    rnd_d       = rnd_q;
    reseed_d    = reseed_q;
    found_d     = found_q;
    rsp_track_d = rsp_track_q;
    rsp_found_d = rsp_found_q;
    x_d         = x_q;
    acc_d       = acc_q;
    opnd_d      = opnd_q;
    mcand_d     = mcand_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    rem_d       = rem_q;

    if (cfg_wr) begin
      case (sps_pkg::reg_index_e'(paddr[sps_pkg::APB_ADDR_W-1]))
        sps_pkg::REG_PLAYLIST_LENGTH: plen_d = pwdata[sps_pkg::LEN_W-1:0];
        default:                      plen_d = plen_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          func_d   = req_i.func;
          rep_d    = req_i.repeat_mode;
          rnd_d    = req_i.random_mode;
          reseed_d = req_i.reseed_value;
          state_d  = ST_CALC;
        end
      end

      // Decide the request; simple cases finish here
      ST_CALC: begin
        found_d = 1'b0;
        state_d = ST_EMIT;
        if (len != '0) begin
          if (rnd_q) begin
            if (!spent || rep_q) begin
              x_d     = gen_q;
              state_d = ST_SETUP;
              // new pass: reseed from the cursor
              if (spent) begin
                sc_d  = func_q ? len : '0;
                gen_d = cur_q;
                inc_d = seed_ib;
                x_d   = cur_q;
              end
            end
          end else begin
            sc_d = '0;
            if (!func_q) begin
              if (rep_q) begin
                num_d   = cur_inc;
                rem_d   = '0;
                cnt_d   = CW'(IB);
                state_d = ST_DIV;
              end else if (cur_inc < {1'b0, len}) begin
                cur_d   = cur_inc[IB-1:0];
                found_d = 1'b1;
              end
            end else if (cur_q == '0) begin
              if (rep_q) begin
                cur_d   = len_m1;
                found_d = 1'b1;
              end
            end else begin
              cur_d   = (cur_m1 >= len) ? len_m1 : cur_m1;
              found_d = 1'b1;
            end
          end
        end
      end

      // Load the shift-and-add multiplier for one generator step
      ST_SETUP: begin
        if (func_q) begin
          acc_d   = '0;
          opnd_d  = x_q - inc_q;
          mcand_d = INV_IB;
        end else begin
          acc_d   = inc_q;
          opnd_d  = x_q;
          mcand_d = MULT_IB;
        end
        cnt_d   = CW'(IB - 1);
        state_d = ST_MUL;
      end

      // One multiplier bit per cycle
      ST_MUL: begin
        if (opnd_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        opnd_d  = opnd_q >> 1;
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_CHECK;
        end
      end

      // Cycle walking: step again while outside the list
      ST_CHECK: begin
        if (walk_x < len) begin
          cur_d   = walk_x;
          gen_d   = walk_x;
          sc_d    = func_q ? (sc_q - IB'(1)) : (sc_q + IB'(1));
          found_d = 1'b1;
          state_d = ST_EMIT;
        end else begin
          x_d     = walk_x;
          state_d = ST_SETUP;
        end
      end

      // (cursor + 1) mod length, one dividend bit per cycle
      ST_DIV: begin
        num_d = num_q << 1;
        rem_d = div_new[IB-1:0];
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          cur_d   = div_new[IB-1:0];
          found_d = 1'b1;
          state_d = ST_EMIT;
        end
      end

      // Hand the response to the output register
      ST_EMIT: begin
        if (slot_free) begin
          rsp_valid_d = 1'b1;
          rsp_track_d = trk_w[sps_pkg::TRACK_W-1:0];
          rsp_found_d = found_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State machine, architectural state and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plen_q      <= '0;
      cur_q       <= '0;
      sc_q        <= '0;
      gen_q       <= sps_pkg::RESET_GEN[IB-1:0];
      inc_q       <= sps_pkg::RESET_INC[IB-1:0];
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      cur_q       <= cur_d;
      sc_q        <= sc_d;
      gen_q       <= gen_d;
      inc_q       <= inc_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload and serial datapath
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    rep_q       <= rep_d;
    rnd_q       <= rnd_d;
    reseed_q    <= reseed_d;
    found_q     <= found_d;
    rsp_track_q <= rsp_track_d;
    rsp_found_q <= rsp_found_d;
    x_q         <= x_d;
    acc_q       <= acc_d;
    opnd_q      <= opnd_d;
    mcand_q     <= mcand_d;
    cnt_q       <= cnt_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
  end

  // Checks
  a_div_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < len))
    else $error("remainder not below list length");

  a_found_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && found_q) |-> (cur_q < len))
    else $error("selected track outside the list");

  a_gen_follows_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && found_q && rnd_q) |-> (gen_q == cur_q))
    else $error("generator not synchronised with shuffled cursor");

  a_accept_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == ST_CALC))
    else $error("accepted request not decoded");

  a_rsp_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("response raised outside emit state");

endmodule

@@ bench/sps_track_checker.sv @@
// Checker for the shuffle playlist sequencer: predicts every track pick and compares responses.
`timescale 1ns / 1ps

module sps_track_checker
  import sps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic                  req_func_i,
  input  logic                  req_repeat_i,
  input  logic                  req_random_i,
  input  logic [SEED_W-1:0]     req_reseed_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  logic [TRACK_W-1:0]    rsp_track_i,
  input  logic                  rsp_found_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int unsigned           err_count_o,
  output int unsigned           pending_o,
  output int unsigned           found_count_o,
  output int unsigned           restart_count_o
);

  typedef struct packed {
    logic [TRACK_W-1:0] track_index;
    logic               found;
  } track_pick_t;

  // Inverse of an odd number mod 2^64, fixed one bit at a time
  function automatic logic [63:0] odd_inverse(input logic [63:0] m);
    logic [63:0] inv;
    inv = 64'd1;
    for (int b = 1; b < 64; b++) begin
      if (((m * inv) >> b) & 64'd1) inv = inv | (64'd1 << b);
    end
    return inv;
  endfunction

  localparam logic [63:0] LCG_MULT     = (64'd6364136223846793005 & ~64'd3) | 64'd1;
  localparam logic [63:0] LCG_MULT_INV = odd_inverse(LCG_MULT);

  // Playlist state as the sequencer should hold it
  logic [LEN_W-1:0]   list_len;
  logic [TRACK_W-1:0] cursor;
  logic [TRACK_W-1:0] pass_count;
  logic [TRACK_W-1:0] lcg_state;
  logic [TRACK_W-1:0] lcg_step;

  track_pick_t pick_q[$];

  // Smallest power of two covering the list, minus one
  function automatic logic [63:0] span_mask(input logic [LEN_W-1:0] n);
    logic [63:0] p;
    p = 64'd1;
    while (p < 64'(n)) p = p << 1;
    return p - 64'd1;
  endfunction

  // Works out the pick for one request and advances the playlist state
  function automatic track_pick_t next_pick(input logic backward, input logic rep,
                                            input logic shuffle,
                                            input logic [SEED_W-1:0] reseed);
    track_pick_t pick;
    logic [63:0] msk;
    logic [63:0] x;
    logic [31:0] nx;
    logic        spent;
    pick.found = 1'b0;
    if (list_len != '0) begin
      if (shuffle) begin
        spent = backward ? (pass_count == '0) : (pass_count >= list_len);
        if (!spent || rep) begin
          // pass used up with repeat: restart from the cursor with a fresh step
          if (spent) begin
            pass_count = backward ? list_len : '0;
            lcg_state  = cursor;
            lcg_step   = reseed | SEED_W'(1);
            restart_count_o++;
          end
          msk = span_mask(list_len);
          x   = 64'(lcg_state);
          // cycle walking: skip values past the end of the list
          for (int k = 0; k <= int'(msk); k++) begin
            if (backward) x = ((x - 64'(lcg_step)) * LCG_MULT_INV) & msk;
            else          x = (LCG_MULT * x + 64'(lcg_step)) & msk;
            if (x < 64'(list_len)) break;
          end
          lcg_state  = x[TRACK_W-1:0];
          cursor     = x[TRACK_W-1:0];
          pass_count = backward ? pass_count - 1'b1 : pass_count + 1'b1;
          pick.found = 1'b1;
        end
      end else begin
        pass_count = '0;
        if (!backward) begin
          nx = rep ? (32'(cursor) + 32'd1) % 32'(list_len) : 32'(cursor) + 32'd1;
          if (nx < 32'(list_len)) begin
            cursor     = nx[TRACK_W-1:0];
            pick.found = 1'b1;
          end
        end else if (cursor == '0) begin
          if (rep) begin
            cursor     = list_len - 1'b1;
            pick.found = 1'b1;
          end
        end else begin
          // a cursor left beyond a shortened list saturates to the last track
          nx = 32'(cursor) - 32'd1;
          if (nx >= 32'(list_len)) nx = 32'(list_len) - 32'd1;
          cursor     = nx[TRACK_W-1:0];
          pick.found = 1'b1;
        end
      end
    end
    pick.track_index = cursor;
    return pick;
  endfunction

  // Responses are compared before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    track_pick_t want;
    track_pick_t pick;
    if (!rst_ni) begin
      list_len        = '0;
      cursor          = '0;
      pass_count      = '0;
      lcg_state       = TRACK_W'(42);
      lcg_step        = TRACK_W'(1013904223);
      pick_q.delete();
      err_count_o     = 0;
      pending_o       = 0;
      found_count_o   = 0;
      restart_count_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (pick_q.size() == 0) begin
          $error("response with no request waiting: track_index %0d found %0b",
                 rsp_track_i, rsp_found_i);
          err_count_o++;
        end else begin
          want = pick_q.pop_front();
          if (rsp_track_i !== want.track_index) begin
            $error("track_index mismatch: expected %0d, got %0d",
                   want.track_index, rsp_track_i);
            err_count_o++;
          end
          if (rsp_found_i !== want.found) begin
            $error("found mismatch: expected %0b, got %0b", want.found, rsp_found_i);
            err_count_o++;
          end
        end
      end
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_index_e'(paddr_i[APB_ADDR_W-1:2]))
          REG_PLAYLIST_LENGTH: list_len = pwdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      // func high asks for the previous track
      if (req_valid_i && req_ready_i) begin
        pick = next_pick(req_func_i, req_repeat_i, req_random_i, req_reseed_i);
        if (pick.found) found_count_o++;
        pick_q.push_back(pick);
      end
      pending_o = pick_q.size();
    end
  end

endmodule

@@ bench/shuffle_playlist_sequencer_tb.sv @@
// Testbench top for the shuffle playlist sequencer: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module shuffle_playlist_sequencer_tb;
  import sps_pkg::*;

  localparam logic        NEXT           = 1'b0;
  localparam logic        PREV           = 1'b1;
  localparam int unsigned SEGMENTS       = 13;
  localparam int unsigned SEGMENT_ITEMS  = 50;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  typedef enum int unsigned {
    MIX_SHUFFLE,
    MIX_SEQUENTIAL,
    MIX_NOISE
  } traffic_mix_e;

  logic clk_i;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sps_req_if req ();
  sps_rsp_if rsp ();

  int unsigned err_count;
  int unsigned pending;
  int unsigned found_count;
  int unsigned restart_count;

  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  logic        hold_go;
  int unsigned sent_total;
  int unsigned lengths_written;

  shuffle_playlist_sequencer #(
    .INDEX_BITS(TRACK_W)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sps_track_checker u_pick_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req.valid),
    .req_ready_i     (req.ready),
    .req_func_i      (req.func),
    .req_repeat_i    (req.repeat_mode),
    .req_random_i    (req.random_mode),
    .req_reseed_i    (req.reseed_value),
    .rsp_valid_i     (rsp.valid),
    .rsp_ready_i     (rsp.ready),
    .rsp_track_i     (rsp.track_index),
    .rsp_found_i     (rsp.found),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .err_count_o     (err_count),
    .pending_o       (pending),
    .found_count_o   (found_count),
    .restart_count_o (restart_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offers one request after a random gap; returns at the falling edge after acceptance
  task automatic send_req(input logic back, input logic rep, input logic shuf,
                          input logic [SEED_W-1:0] seed);
    while ($urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid        <= 1'b1;
    req.func         <= back;
    req.repeat_mode  <= rep;
    req.random_mode  <= shuf;
    req.reseed_value <= seed;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    sent_total++;
  endtask

  // Stops offering and waits until every pick has been answered
  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Register write: setup cycle then access cycle, upper data bits are noise
  task automatic apb_write(input reg_index_e idx, input logic [LEN_W-1:0] value);
    logic [APB_DATA_W-1:0] data;
    data            = $urandom;
    data[LEN_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(int'(idx) * 4);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    drain();
    apb_write(REG_PLAYLIST_LENGTH, len);
    lengths_written++;
  endtask

  // Mostly short lists, some mid-sized, a few at the edges of the range
  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return LEN_W'($urandom_range(12, 1));
    if (r < 75) return LEN_W'($urandom_range(300, 13));
    if (r < 80) return '1;
    if (r < 84) return LEN_W'($urandom_range(1));
    if (r < 90) return LEN_W'((1 << $urandom_range(15, 1)) + $urandom_range(1));
    return LEN_W'($urandom);
  endfunction

  // One stretch of traffic with a given mix; shuffle stretches may favour one direction
  task automatic random_segment(input int unsigned n_items);
    traffic_mix_e mix;
    int unsigned  back_pct;
    logic         back;
    logic         rep;
    logic         shuf;
    mix      = traffic_mix_e'($urandom_range(2));
    back_pct = ($urandom_range(2) == 0) ? 10 : ($urandom_range(1) ? 50 : 85);
    for (int i = 0; i < n_items; i++) begin
      case (mix)
        MIX_SHUFFLE: begin
          shuf = ($urandom_range(99) < 92);
          back = ($urandom_range(99) < back_pct);
          rep  = ($urandom_range(99) < 70);
        end
        MIX_SEQUENTIAL: begin
          shuf = ($urandom_range(99) < 8);
          back = ($urandom_range(99) < 40);
          rep  = 1'($urandom_range(1));
        end
        default: begin
          shuf = 1'($urandom_range(1));
          back = 1'($urandom_range(1));
          rep  = 1'($urandom_range(1));
        end
      endcase
      send_req(back, rep, shuf, SEED_W'($urandom));
    end
  endtask

  // Response side: random stalls, or a long hold-off when asked
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_go  <= 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // Watchdog: too long without any request, response or register write
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni           = 1'b0;
    req.valid        = 1'b0;
    req.func         = NEXT;
    req.repeat_mode  = 1'b0;
    req.random_mode  = 1'b0;
    req.reseed_value = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    hold_go          = 1'b0;
    req_idle_pct     = 0;
    rsp_idle_pct     = 0;
    sent_total       = 0;
    lengths_written  = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list after reset: nothing is ever found
    send_req(NEXT, 1'b0, 1'b0, 16'h0000);
    send_req(PREV, 1'b1, 1'b1, 16'hFFFF);

    // sequential walk on three tracks, both ends, with and without repeat
    set_length(16'd3);
    send_req(NEXT, 1'b0, 1'b0, 16'h0000);
    send_req(NEXT, 1'b0, 1'b0, 16'h0000);
    send_req(NEXT, 1'b0, 1'b0, 16'h0000);
    send_req(PREV, 1'b0, 1'b0, 16'h0000);
    send_req(PREV, 1'b0, 1'b0, 16'h0000);
    send_req(PREV, 1'b0, 1'b0, 16'h0000);
    send_req(PREV, 1'b1, 1'b0, 16'h0000);
    send_req(NEXT, 1'b1, 1'b0, 16'h0000);

    // shuffle: one full pass, spent pass, restart, then backwards
    send_req(NEXT, 1'b0, 1'b1, 16'h0000);
    send_req(NEXT, 1'b0, 1'b1, 16'h0000);
    send_req(NEXT, 1'b0, 1'b1, 16'h0000);
    send_req(NEXT, 1'b0, 1'b1, 16'h0000);
    send_req(NEXT, 1'b1, 1'b1, 16'h0000);
    send_req(PREV, 1'b0, 1'b1, 16'h0000);
    send_req(PREV, 1'b0, 1'b1, 16'h0000);
    send_req(PREV, 1'b1, 1'b1, 16'hFFFF);

    // single track: the generator range collapses to one value
    set_length(16'd1);
    send_req(NEXT, 1'b1, 1'b1, 16'h5555);
    send_req(PREV, 1'b1, 1'b1, 16'hAAAA);

    // longest list, then shrink it under the cursor
    set_length(16'hFFFF);
    send_req(PREV, 1'b1, 1'b0, 16'h0000);
    set_length(16'd5);
    send_req(NEXT, 1'b1, 1'b0, 16'h0000);
    set_length(16'hFFFF);
    send_req(PREV, 1'b1, 1'b0, 16'h0000);
    send_req(NEXT, 1'b1, 1'b1, 16'hAAAA);
    send_req(PREV, 1'b0, 1'b1, 16'h0001);
    set_length(16'd5);
    send_req(PREV, 1'b0, 1'b0, 16'h0000);

    // random traffic in three stall regimes
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5) begin
        req_idle_pct  = 27;
        rsp_idle_pct <= 63;
      end else if (seg < 9) begin
        req_idle_pct  = 63;
        rsp_idle_pct <= 27;
      end else begin
        req_idle_pct  = 0;
        rsp_idle_pct <= 0;
      end
      set_length(pick_length());
      // hold responses back while requests keep coming, so the input stalls
      if (seg == 9) hold_go <= 1'b1;
      random_segment(SEGMENT_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d requests over %0d list lengths: %0d tracks found, %0d pass restarts.",
             sent_total, lengths_written, found_count, restart_count);
    $display("Both stall mixes, a %0d-cycle response hold-off and stall-free traffic were run.",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sps_pkg.sv
rtl/core/sps_if.sv
rtl/core/shuffle_playlist_sequencer.sv
bench/sps_track_checker.sv
bench/shuffle_playlist_sequencer_tb.sv
